/* hw/rtl/newton_square_root_unit_defines.svh */
// assertion macros of the newton square root unit checker
// no dependencies; include by bare file name inside a module body
`ifndef NEWTON_SQUARE_ROOT_UNIT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define NSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nsr assertion failed");

// next-cycle implication, disabled while reset is low
`define NSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nsr assertion failed");

// next-cycle implication that also runs during reset
`define NSR_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nsr assertion failed");

`endif

/* hw/rtl/nsr_pkg.sv */
// shared types, constants and microcode program of the newton square root unit
// no dependencies; imported by the datapath, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

    // default parameter values
    localparam int DEF_FRAC_BITS      = 30;
    localparam int DEF_INT_BITS       = 32;
    localparam int DEF_MAX_ITERATIONS = 64;

    // quotient and guess width, saturation value of the quotient
    localparam int QW = 63;
    localparam logic [QW-1:0] Q_SAT = '1;

    // tolerance register
    localparam int TOL_W = 10;
    localparam logic [TOL_W-1:0] TOL_RESET = 10'd2;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NEG   = 2'd1;
    localparam t_status ST_LIMIT = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CHECK,
        OP_GFIX,
        OP_DIV,
        OP_MEAN,
        OP_TEST,
        OP_LOOP,
        OP_LIMIT,
        OP_SNAP,
        OP_EMIT
    } t_op;

    // sequencer conditions
    typedef enum logic [2:0] {
        C_NEXT,     // go to the following step
        C_JUMP,     // go to the target
        C_ACCEPT,   // stay until an input transaction, then the following step
        C_EARLY,    // negative or zero input: go to the target
        C_DIV,      // stay until the last division step
        C_CONV,     // converged: go to the target
        C_MORE,     // iterations left: go to the target
        C_EMIT      // stay until the output register is free, then the target
    } t_cond;

    typedef logic [3:0] t_upc;
    localparam t_upc UPC_IDLE  = 4'd0;
    localparam t_upc UPC_CHECK = 4'd1;
    localparam t_upc UPC_GFIX  = 4'd2;
    localparam t_upc UPC_DIV   = 4'd3;
    localparam t_upc UPC_MEAN  = 4'd4;
    localparam t_upc UPC_TEST  = 4'd5;
    localparam t_upc UPC_LOOP  = 4'd6;
    localparam t_upc UPC_LIMIT = 4'd7;
    localparam t_upc UPC_SNAP  = 4'd8;
    localparam t_upc UPC_EMIT  = 4'd9;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic neg;
        logic zero;
        logic div_last;
        logic conv;
        logic more;
    } t_flags;

    // microcode program
    function automatic t_uword ucode_rom(input t_upc upc);
        t_uword w;
        case (upc)
            UPC_IDLE:  w = '{op: OP_IDLE,  cond: C_ACCEPT, target: UPC_IDLE};
            UPC_CHECK: w = '{op: OP_CHECK, cond: C_EARLY,  target: UPC_EMIT};
            UPC_GFIX:  w = '{op: OP_GFIX,  cond: C_NEXT,   target: UPC_IDLE};
            UPC_DIV:   w = '{op: OP_DIV,   cond: C_DIV,    target: UPC_IDLE};
            UPC_MEAN:  w = '{op: OP_MEAN,  cond: C_NEXT,   target: UPC_IDLE};
            UPC_TEST:  w = '{op: OP_TEST,  cond: C_CONV,   target: UPC_SNAP};
            UPC_LOOP:  w = '{op: OP_LOOP,  cond: C_MORE,   target: UPC_GFIX};
            UPC_LIMIT: w = '{op: OP_LIMIT, cond: C_JUMP,   target: UPC_EMIT};
            UPC_SNAP:  w = '{op: OP_SNAP,  cond: C_NEXT,   target: UPC_IDLE};
            UPC_EMIT:  w = '{op: OP_EMIT,  cond: C_EMIT,   target: UPC_IDLE};
            default:   w = '{op: OP_IDLE,  cond: C_JUMP,   target: UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/newton_square_root_unit.sv */
// Newton square root unit. Input stream: s_axis_tdata carries the signed Q32.30 radicand.
// Output stream: m_axis_tdata carries the unsigned Q17.30 root, m_axis_tuser the status
// (ok, negative input, iteration limit). One result per input transaction.
// A negative or zero radicand goes from the check step straight to the emit step.
// Otherwise each Newton step runs the serial divider of NE bits, one quotient bit a cycle.
// One item is in flight at a time: s_axis_tready is high only while the sequencer idles.
// The result sits in an output register; a new item is accepted while it waits, and
// the sequencer holds its last step if the register is still full when the next
// result is ready. Reset clears the sequencer, drops m_axis_tvalid and sets the
// tolerance register to 2 LSBs. i_cfg_wen writes the tolerance; the user must write it only
// while the unit is idle, which the unit itself does not enforce.
// depends on nsr_pkg and nsr_datapath
`timescale 1ns / 1ps
`default_nettype none

module newton_square_root_unit #(
    parameter int FRAC_BITS       = nsr_pkg::DEF_FRAC_BITS,
    parameter int INT_BITS        = nsr_pkg::DEF_INT_BITS,
    parameter int MAX_ITERATIONS  = nsr_pkg::DEF_MAX_ITERATIONS,
    localparam int RAD_BITS       = INT_BITS + FRAC_BITS + 1,
    localparam int ROOT_BITS      = INT_BITS / 2 + FRAC_BITS + 1,
    localparam int IN_TDATA_W     = ((RAD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W    = ((ROOT_BITS + 7) / 8) * 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // tolerance register write
    input  wire logic                      i_cfg_wen,
    input  wire logic [nsr_pkg::TOL_W-1:0] i_cfg_wdata,
    // input stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]     s_axis_tdata,   // radicand, then zero pad
    // output stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata,   // root, then zero pad
    output logic [1:0]                     m_axis_tuser    // status
);
    import nsr_pkg::*;

    logic [TOL_W-1:0]     r_tol;
    t_upc                 r_upc;
    t_upc                 n_upc;
    logic                 r_m_tvalid;
    logic                 n_m_tvalid;
    logic [ROOT_BITS-1:0] r_m_root;
    t_status              r_m_status;

    t_uword               uword;
    t_flags               flags;
    logic                 accept;
    logic                 out_free;
    logic                 emit;
    logic [ROOT_BITS-1:0] dp_root;
    t_status              dp_status;

    // current control word
    assign uword    = ucode_rom(r_upc);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_tvalid || m_axis_tready;
    assign emit     = (uword.op == OP_EMIT) && out_free;

    // step sequencing
    always_comb begin
        case (uword.cond)
            C_NEXT:   n_upc = r_upc + t_upc'(1);
            C_JUMP:   n_upc = uword.target;
            C_ACCEPT: n_upc = accept ? r_upc + t_upc'(1) : r_upc;
            C_EARLY:  n_upc = (flags.neg || flags.zero) ? uword.target : r_upc + t_upc'(1);
            C_DIV:    n_upc = flags.div_last ? r_upc + t_upc'(1) : r_upc;
            C_CONV:   n_upc = flags.conv ? uword.target : r_upc + t_upc'(1);
            C_MORE:   n_upc = flags.more ? uword.target : r_upc + t_upc'(1);
            C_EMIT:   n_upc = out_free ? uword.target : r_upc;
            default:  n_upc = UPC_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        n_m_tvalid = r_m_tvalid;
        if (emit) begin
            n_m_tvalid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc      <= UPC_IDLE;
            r_m_tvalid <= 1'b0;
            r_tol      <= TOL_RESET;
        end else begin
            r_upc      <= n_upc;
            r_m_tvalid <= n_m_tvalid;
            if (i_cfg_wen) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_root   <= dp_root;
            r_m_status <= dp_status;
        end
    end

    nsr_datapath #(
        .FRAC_BITS      (FRAC_BITS),
        .INT_BITS       (INT_BITS),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_nsr_datapath (
        .i_clk      (i_clk),
        .i_op       (uword.op),
        .i_load     (accept),
        .i_radicand (s_axis_tdata[RAD_BITS-1:0]),
        .i_tol      (r_tol),
        .o_flags    (flags),
        .o_root     (dp_root),
        .o_status   (dp_status)
    );

    assign s_axis_tready = (uword.op == OP_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-ROOT_BITS){1'b0}}, r_m_root};
    assign m_axis_tuser  = r_m_status;

endmodule

`default_nettype wire

/* hw/rtl/nsr_datapath.sv */
// datapath of the newton square root unit: guess, bit-serial divider, mean and snap
// depends on nsr_pkg; driven one operation per cycle by the microcode sequencer
`timescale 1ns / 1ps
`default_nettype none

module nsr_datapath #(
    parameter int FRAC_BITS      = nsr_pkg::DEF_FRAC_BITS,
    parameter int INT_BITS       = nsr_pkg::DEF_INT_BITS,
    parameter int MAX_ITERATIONS = nsr_pkg::DEF_MAX_ITERATIONS,
    localparam int RAD_BITS      = INT_BITS + FRAC_BITS + 1,
    localparam int ROOT_BITS     = INT_BITS / 2 + FRAC_BITS + 1
) (
    input  wire logic                        i_clk,
    input  wire nsr_pkg::t_op                i_op,
    input  wire logic                        i_load,
    input  wire logic [RAD_BITS-1:0]         i_radicand,
    input  wire logic [nsr_pkg::TOL_W-1:0]   i_tol,
    output nsr_pkg::t_flags                  o_flags,
    output logic [ROOT_BITS-1:0]             o_root,
    output nsr_pkg::t_status                 o_status
);
    import nsr_pkg::*;

    localparam int XW = RAD_BITS - 1;
    localparam int RW = QW + 1;
    localparam int NE = (XW + FRAC_BITS > QW + 1) ? XW + FRAC_BITS : QW + 1;
    localparam int CW = $clog2(NE + 1);
    localparam int IW = $clog2(MAX_ITERATIONS + 1);
    localparam logic [QW-1:0] FIX_ONE  = {{(QW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [RW-1:0] HALF_W   = {1'b0, FIX_ONE >> 1};
    localparam logic [RW-1:0] FRAC_MSK = {1'b0, FIX_ONE - {{(QW-1){1'b0}}, 1'b1}};

    logic [RAD_BITS-1:0]  r_x;
    logic [QW-1:0]        r_g;
    logic [QW-1:0]        r_g2;
    logic [NE-1:0]        r_num;
    logic [QW-1:0]        r_rem;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        r_it;
    logic [ROOT_BITS-1:0] r_root;
    t_status              r_status;

    logic [XW-1:0] x_mag;
    logic [QW-1:0] x_ext;
    logic [QW-1:0] g_init;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] rem_sub;
    logic          div_ge;
    logic [QW-1:0] rem_nx;
    logic [QW-1:0] quo_sat;
    logic [RW-1:0] mean_sum;
    logic [QW-1:0] diff;
    logic [QW-1:0] tol_ext;
    logic [RW-1:0] g2_ext;
    logic [RW-1:0] rnd_sum;
    logic [RW-1:0] rnd;
    logic [RW-1:0] d2;
    logic [RW-1:0] snap_val;

    // clamp a wide value into the root field
    function automatic logic [ROOT_BITS-1:0] sat_root(input logic [RW-1:0] v);
        logic [ROOT_BITS-1:0] res;
        res = (|v[RW-1:ROOT_BITS]) ? '1 : v[ROOT_BITS-1:0];
        return res;
    endfunction

    // starting guess
    assign x_mag  = r_x[XW-1:0];
    assign x_ext  = {{(QW-XW){1'b0}}, x_mag};
    assign g_init = (x_ext >= FIX_ONE) ? (x_ext >> 1) : FIX_ONE;

    // one restoring division step
    assign rem_sh  = {r_rem, r_num[NE-1]};
    assign rem_sub = rem_sh - {1'b0, r_g};
    assign div_ge  = (rem_sh >= {1'b0, r_g});
    assign rem_nx  = div_ge ? rem_sub[QW-1:0] : rem_sh[QW-1:0];

    // saturated quotient and mean of guess and quotient
    assign quo_sat  = (|r_num[NE-1:QW]) ? Q_SAT : r_num[QW-1:0];
    assign mean_sum = {1'b0, r_g} + {1'b0, quo_sat};

    // convergence test
    assign diff    = (r_g > r_g2) ? (r_g - r_g2) : (r_g2 - r_g);
    assign tol_ext = {{(QW-TOL_W){1'b0}}, i_tol};

    // snap to the nearest integer, ties up, if it lies within the tolerance
    assign g2_ext   = {1'b0, r_g2};
    assign rnd_sum  = g2_ext + HALF_W;
    assign rnd      = rnd_sum & ~FRAC_MSK;
    assign d2       = (g2_ext > rnd) ? (g2_ext - rnd) : (rnd - g2_ext);
    assign snap_val = (d2 < {1'b0, tol_ext}) ? rnd : g2_ext;

    // operation registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_IDLE: begin
                if (i_load) begin
                    r_x <= i_radicand;
                end
            end
            OP_CHECK: begin
                r_g      <= g_init;
                r_it     <= '0;
                r_root   <= '0;
                r_status <= r_x[RAD_BITS-1] ? ST_NEG : ST_OK;
            end
            OP_GFIX: begin
                if (r_g == '0) begin
                    r_g <= {{(QW-1){1'b0}}, 1'b1};
                end
                r_num <= {{(NE-XW){1'b0}}, x_mag} << FRAC_BITS;
                r_rem <= '0;
                r_cnt <= CW'(NE);
            end
            OP_DIV: begin
                r_rem <= rem_nx;
                r_num <= {r_num[NE-2:0], div_ge};
                r_cnt <= r_cnt - {{(CW-1){1'b0}}, 1'b1};
            end
            OP_MEAN: begin
                r_g2 <= mean_sum[RW-1:1];
            end
            OP_LOOP: begin
                r_g  <= r_g2;
                r_it <= r_it + {{(IW-1){1'b0}}, 1'b1};
            end
            OP_LIMIT: begin
                r_root   <= sat_root(g2_ext);
                r_status <= ST_LIMIT;
            end
            OP_SNAP: begin
                r_root   <= sat_root(snap_val);
                r_status <= ST_OK;
            end
            default: begin
            end
        endcase
    end

    // flags for the sequencer
    assign o_flags.neg      = r_x[RAD_BITS-1];
    assign o_flags.zero     = (x_mag == '0);
    assign o_flags.div_last = (r_cnt == {{(CW-1){1'b0}}, 1'b1});
    assign o_flags.conv     = (diff < tol_ext);
    assign o_flags.more     = (r_it != IW'(MAX_ITERATIONS - 1));

    assign o_root   = r_root;
    assign o_status = r_status;

endmodule

`default_nettype wire

/* hw/rtl/nsr_checker.sv */
// port-level checker of the newton square root unit, bound to the top level
// depends on nsr_pkg and newton_square_root_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none

module nsr_checker #(
    parameter int DATA_W = 48
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [DATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]        m_axis_tuser
);
    import nsr_pkg::*;
    `include "newton_square_root_unit_defines.svh"

    logic              out_wait;
    logic              in_xfer;
    logic              out_neg;
    logic              code_ok;
    logic [DATA_W+1:0] out_word;

    // port conditions
    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_neg  = m_axis_tvalid && (m_axis_tuser == ST_NEG);
    assign code_ok  = (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_NEG)
                   || (m_axis_tuser == ST_LIMIT);
    assign out_word = {m_axis_tuser, m_axis_tdata};

    // a stalled result holds
    `NSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, m_axis_tvalid && $stable(out_word))

    // one item at a time: no second input transaction right after one
    `NSR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_xfer, !s_axis_tready)

    // negative input gives a zero root, and status is one of the defined codes
    `NSR_ASSERT_IMPL(a_neg_zero, i_clk, i_rst_n, out_neg, m_axis_tdata == '0)
    `NSR_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, m_axis_tvalid, code_ok)

    // reset empties the output register
    `NSR_ASSERT_NEXT_ANY(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind newton_square_root_unit nsr_checker #(
    .DATA_W (OUT_TDATA_W)
) u_nsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
